>>> src/pf_pkg.sv
`timescale 1ns / 1ps
package pf_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int EXP_BITS    = 5;
  localparam int DIV_BITS    = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS     = 2 * DIV_BITS;
  localparam int SQ_PAD      = SQ_BITS - VALUE_BITS;
  localparam int VALUE_PAD   = VALUE_BITS - DIV_BITS;
  localparam int MAX_RESULTS = 9;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int STEP_BITS   = $clog2(VALUE_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [EXP_BITS-1:0]   EXP_MAX    = '1;
  localparam logic [DIV_BITS-1:0]   FIRST_DIV  = DIV_BITS'(2);
  localparam logic [DIV_BITS-1:0]   SECOND_DIV = DIV_BITS'(3);
  localparam logic [DIV_BITS-1:0]   DIV_STRIDE = DIV_BITS'(2);
  localparam logic [VALUE_BITS-1:0] MIN_VALUE  = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] UNIT_VALUE = VALUE_BITS'(1);
  localparam logic [STEP_BITS-1:0]  LAST_STEP  = STEP_BITS'(VALUE_BITS - 1);
  localparam logic [CNT_BITS-1:0]   CNT_LIMIT  = CNT_BITS'(MAX_RESULTS);
  localparam logic [QCNT_BITS-1:0]  QUEUE_FULL = QCNT_BITS'(QUEUE_DEPTH);

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic   valid;
    value_t number;
  } pf_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_DIVIDE,
    ST_DECIDE,
    ST_EMIT,
    ST_TAIL,
    ST_FLUSH
  } pf_state_t;

endpackage

>>> src/pf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pf_front (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [pf_pkg::VALUE_BITS-1:0] in_number,
  input  wire logic                       q_full,
  output pf_pkg::pf_item_t                push
);

  // drop values below two: they have no factors
  assign in_stall    = q_full;
  assign push.valid  = in_valid && !q_full && (in_number >= pf_pkg::MIN_VALUE);
  assign push.number = in_number;

endmodule
`default_nettype wire

>>> src/pf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pf_pkg::pf_item_t  push,
  input  wire logic              pop,
  output pf_pkg::pf_item_t       head,
  output logic                   full
);

  pf_pkg::value_t                      mem_r [pf_pkg::QUEUE_DEPTH];
  logic [pf_pkg::QPTR_BITS-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [pf_pkg::QPTR_BITS-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [pf_pkg::QCNT_BITS-1:0]        count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.number;
    end
  end

  assign head.valid  = (count_r != '0);
  assign head.number = mem_r[rd_ptr_r];
  assign full        = (count_r == pf_pkg::QUEUE_FULL);

endmodule
`default_nettype wire

>>> src/pf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pf_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pf_pkg::pf_item_t               head,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pf_pkg::VALUE_BITS-1:0]       out_prime_factor,
  output logic [pf_pkg::EXP_BITS-1:0]         out_exponent,
  output logic                                out_last_factor
);

  pf_pkg::pf_state_t                state_r, state_nxt;
  pf_pkg::value_t                   rest_r, rest_nxt;
  logic [pf_pkg::DIV_BITS-1:0]      div_r, div_nxt;
  logic [pf_pkg::SQ_BITS-1:0]       sq_r, sq_nxt;
  pf_pkg::value_t                   quo_r, quo_nxt;
  logic [pf_pkg::DIV_BITS:0]        rem_r, rem_nxt;
  logic [pf_pkg::STEP_BITS-1:0]     step_r, step_nxt;
  logic [pf_pkg::EXP_BITS-1:0]      exp_r, exp_nxt;
  logic [pf_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic                             pend_valid_r, pend_valid_nxt;
  pf_pkg::value_t                   pend_prime_r, pend_prime_nxt;
  logic [pf_pkg::EXP_BITS-1:0]      pend_exp_r, pend_exp_nxt;
  logic                             out_valid_r, out_valid_nxt;
  pf_pkg::value_t                   out_prime_r, out_prime_nxt;
  logic [pf_pkg::EXP_BITS-1:0]      out_exp_r, out_exp_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             out_free;
  logic                             test_go;
  logic                             tail_take;
  logic [pf_pkg::DIV_BITS:0]        rem_sh;
  logic                             rem_ge;
  logic [pf_pkg::DIV_BITS-1:0]      div_step;
  logic [pf_pkg::SQ_BITS-1:0]       rest_wide;
  logic [pf_pkg::EXP_BITS-1:0]      exp_inc;
  pf_pkg::value_t                   div_wide;

  function automatic logic [pf_pkg::SQ_BITS-1:0] SQ_BITS_MUL(
    input logic [pf_pkg::DIV_BITS-1:0] d
  );
    logic [pf_pkg::SQ_BITS-1:0] dw;
    dw = {{pf_pkg::DIV_BITS{1'b0}}, d};
    return dw * dw;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign rest_wide = {{pf_pkg::SQ_PAD{1'b0}}, rest_r};
  assign test_go   = (sq_r <= rest_wide) && (cnt_r < pf_pkg::CNT_LIMIT);
  assign tail_take = (rest_r > pf_pkg::UNIT_VALUE) && (cnt_r < pf_pkg::CNT_LIMIT);
  assign rem_sh    = {rem_r[pf_pkg::DIV_BITS-1:0], quo_r[pf_pkg::VALUE_BITS-1]};
  assign rem_ge    = rem_sh >= {1'b0, div_r};
  assign div_step  = (div_r == pf_pkg::FIRST_DIV) ? pf_pkg::SECOND_DIV
                                                  : div_r + pf_pkg::DIV_STRIDE;
  assign exp_inc   = (exp_r == pf_pkg::EXP_MAX) ? exp_r : exp_r + 1'b1;
  assign div_wide  = {{pf_pkg::VALUE_PAD{1'b0}}, div_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pf_pkg::ST_IDLE: begin
        if (head.valid) begin
          state_nxt = pf_pkg::ST_SQUARE;
        end
      end
      pf_pkg::ST_SQUARE: begin
        state_nxt = pf_pkg::ST_TEST;
      end
      pf_pkg::ST_TEST: begin
        state_nxt = test_go ? pf_pkg::ST_DIVIDE : pf_pkg::ST_TAIL;
      end
      pf_pkg::ST_DIVIDE: begin
        if (step_r == pf_pkg::LAST_STEP) begin
          state_nxt = pf_pkg::ST_DECIDE;
        end
      end
      pf_pkg::ST_DECIDE: begin
        if (rem_r == '0) begin
          state_nxt = pf_pkg::ST_DIVIDE;
        end else if (exp_r != '0) begin
          state_nxt = pf_pkg::ST_EMIT;
        end else begin
          state_nxt = pf_pkg::ST_SQUARE;
        end
      end
      pf_pkg::ST_EMIT: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = pf_pkg::ST_SQUARE;
        end
      end
      pf_pkg::ST_TAIL: begin
        if (!tail_take || !pend_valid_r || out_free) begin
          state_nxt = pf_pkg::ST_FLUSH;
        end
      end
      pf_pkg::ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = pf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    rest_nxt       = rest_r;
    div_nxt        = div_r;
    sq_nxt         = sq_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    exp_nxt        = exp_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_prime_nxt = pend_prime_r;
    pend_exp_nxt   = pend_exp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_prime_nxt  = out_prime_r;
    out_exp_nxt    = out_exp_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      pf_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop            = 1'b1;
          rest_nxt       = head.number;
          div_nxt        = pf_pkg::FIRST_DIV;
          exp_nxt        = '0;
          cnt_nxt        = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      pf_pkg::ST_SQUARE: begin
        sq_nxt = SQ_BITS_MUL(div_r);
      end
      pf_pkg::ST_TEST: begin
        if (test_go) begin
          quo_nxt  = rest_r;
          rem_nxt  = '0;
          step_nxt = '0;
        end
      end
      pf_pkg::ST_DIVIDE: begin
        rem_nxt  = rem_ge ? rem_sh - {1'b0, div_r} : rem_sh;
        quo_nxt  = {quo_r[pf_pkg::VALUE_BITS-2:0], rem_ge};
        step_nxt = step_r + 1'b1;
      end
      pf_pkg::ST_DECIDE: begin
        if (rem_r == '0) begin
          rest_nxt = quo_r;
          exp_nxt  = exp_inc;
          rem_nxt  = '0;
          step_nxt = '0;
        end else if (exp_r == '0) begin
          div_nxt = div_step;
        end
      end
      pf_pkg::ST_EMIT: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = pend_prime_r;
            out_exp_nxt   = pend_exp_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_prime_nxt = div_wide;
          pend_exp_nxt   = exp_r;
          cnt_nxt        = cnt_r + 1'b1;
          exp_nxt        = '0;
          div_nxt        = div_step;
        end
      end
      pf_pkg::ST_TAIL: begin
        if (tail_take && (!pend_valid_r || out_free)) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = pend_prime_r;
            out_exp_nxt   = pend_exp_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_prime_nxt = rest_r;
          pend_exp_nxt   = pf_pkg::EXP_BITS'(1);
          cnt_nxt        = cnt_r + 1'b1;
        end
      end
      pf_pkg::ST_FLUSH: begin
        if (pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_prime_nxt  = pend_prime_r;
          out_exp_nxt    = pend_exp_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pf_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    div_r        <= div_nxt;
    sq_r         <= sq_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    exp_r        <= exp_nxt;
    cnt_r        <= cnt_nxt;
    pend_prime_r <= pend_prime_nxt;
    pend_exp_r   <= pend_exp_nxt;
    out_prime_r  <= out_prime_nxt;
    out_exp_r    <= out_exp_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prime_factor = out_prime_r;
  assign out_exponent     = out_exp_r;
  assign out_last_factor  = out_last_r;

endmodule
`default_nettype wire

>>> src/prime_factorizer_top.sv
// Each number is factored by trial division with a serial divider: divisor 2, then odd
// divisors up to the square root of the remaining value, plus one more division per repeat of a factor.
// Worst case for a 31-bit prime is roughly 23170 trial divisors.
// Throughput: one number at a time in the serial divider; a two-beat queue feeds it.
// Reset: synchronous, active low; clears queue, engine state and output valid.
`timescale 1ns / 1ps
`default_nettype none
module prime_factorizer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pf_pkg::VALUE_BITS-1:0]  in_number,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pf_pkg::VALUE_BITS-1:0]       out_prime_factor,
  output logic [pf_pkg::EXP_BITS-1:0]         out_exponent,
  output logic                                out_last_factor
);

  pf_pkg::pf_item_t push_s;
  pf_pkg::pf_item_t head_s;
  logic             qfull_s;
  logic             pop_s;

  pf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_number (in_number),
    .q_full    (qfull_s),
    .push      (push_s)
  );

  pf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_s),
    .pop   (pop_s),
    .head  (head_s),
    .full  (qfull_s)
  );

  pf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head_s),
    .pop              (pop_s),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prime_factor (out_prime_factor),
    .out_exponent     (out_exponent),
    .out_last_factor  (out_last_factor)
  );

  a_drop_small: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_number < pf_pkg::MIN_VALUE)) |-> !push_s.valid)
    else $error("value below two entered the queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_s.valid |-> !qfull_s)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_s |-> head_s.valid)
    else $error("pop from empty queue");

  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_exponent != '0) && (out_prime_factor >= pf_pkg::MIN_VALUE)))
    else $error("result beat with zero exponent or prime below two");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    pf_pkg::value_t                prime_factor;
    logic [pf_pkg::EXP_BITS-1:0]   exponent;
    logic                          last_factor;
  } factor_t;

  localparam longint unsigned VALUE_LIMIT = (64'd1 << pf_pkg::VALUE_BITS) - 64'd1;
  localparam int NUM_SMALL = 25;
  localparam int unsigned SMALL_PRIMES [0:NUM_SMALL-1] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
    53, 59, 61, 67, 71, 73, 79, 83, 89, 97
  };
  localparam int IDLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 100;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  pf_pkg::value_t                in_number = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pf_pkg::value_t                out_prime_factor;
  logic [pf_pkg::EXP_BITS-1:0]   out_exponent;
  logic                          out_last_factor;

  factor_t pending_factors [$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 1'b0;
  int      stall_left = 0;
  int      free_left = 0;

  prime_factorizer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prime_factor (out_prime_factor),
    .out_exponent     (out_exponent),
    .out_last_factor  (out_last_factor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_factors(input pf_pkg::value_t number);
    longint unsigned rest;
    longint unsigned divisor;
    factor_t         found [$];
    factor_t         f;
    rest = number;
    divisor = 2;
    if (rest < 2) return;
    while (divisor <= rest / divisor && found.size() < pf_pkg::MAX_RESULTS) begin
      if (rest % divisor == 0) begin
        f.prime_factor = pf_pkg::value_t'(divisor);
        f.exponent = '0;
        f.last_factor = 1'b0;
        while (rest % divisor == 0) begin
          rest = rest / divisor;
          if (f.exponent != pf_pkg::EXP_MAX) f.exponent = f.exponent + 1'b1;
        end
        found.push_back(f);
      end
      divisor++;
    end
    if (rest > 1 && found.size() < pf_pkg::MAX_RESULTS) begin
      f.prime_factor = pf_pkg::value_t'(rest);
      f.exponent = pf_pkg::EXP_BITS'(1);
      f.last_factor = 1'b0;
      found.push_back(f);
    end
    if (found.size() > 0) found[found.size() - 1].last_factor = 1'b1;
    foreach (found[i]) pending_factors.push_back(found[i]);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic send_number(input pf_pkg::value_t number);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (in_stall);
    predict_factors(number);
  endtask

  function automatic pf_pkg::value_t smooth_number();
    longint unsigned acc;
    longint unsigned p;
    int              steps;
    int              idx;
    acc = 1;
    steps = $urandom_range(1, 40);
    for (int i = 0; i < steps; i++) begin
      idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, NUM_SMALL - 1);
      p = SMALL_PRIMES[idx];
      if (acc * p <= VALUE_LIMIT) acc = acc * p;
    end
    if ($urandom_range(0, 2) == 0) begin
      p = $urandom_range(2, 1023);
      if (acc * p <= VALUE_LIMIT) acc = acc * p;
    end
    return pf_pkg::value_t'(acc);
  endfunction

  task automatic test_no_factors();
    send_number(pf_pkg::value_t'(0));
    send_number(pf_pkg::value_t'(1));
  endtask

  task automatic test_primes();
    send_number(pf_pkg::value_t'(2));
    send_number(pf_pkg::value_t'(3));
    send_number(pf_pkg::value_t'(65521));
  endtask

  task automatic test_exponents();
    send_number(pf_pkg::value_t'(4));
    send_number(pf_pkg::value_t'(1073741824));
    send_number(pf_pkg::value_t'(1162261467));
    send_number(pf_pkg::value_t'(1220703125));
    send_number(pf_pkg::value_t'(9409));
  endtask

  task automatic test_many_factors();
    send_number(pf_pkg::value_t'(223092870));
    send_number(pf_pkg::value_t'(446185740));
    send_number(pf_pkg::value_t'(1073741823));
    send_number(pf_pkg::value_t'(2147483646));
  endtask

  task automatic test_all_ones();
    send_number('1);
  endtask

  task automatic test_random_numbers();
    pf_pkg::value_t number;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) number = pf_pkg::value_t'($urandom_range(0, 4095));
      else number = smooth_number();
      send_number(number);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left = free_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 3);
      free_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    factor_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_factors.size() == 0) begin
        $error("unexpected beat: prime_factor %0d exponent %0d last_factor %0b",
               out_prime_factor, out_exponent, out_last_factor);
        error_count++;
      end else begin
        want = pending_factors.pop_front();
        if (out_prime_factor !== want.prime_factor) begin
          $error("prime_factor: expected %0d, got %0d", want.prime_factor, out_prime_factor);
          error_count++;
        end
        if (out_exponent !== want.exponent) begin
          $error("exponent: expected %0d, got %0d", want.exponent, out_exponent);
          error_count++;
        end
        if (out_last_factor !== want.last_factor) begin
          $error("last_factor: expected %0b, got %0b", want.last_factor, out_last_factor);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_factors();
    test_primes();
    test_exponents();
    test_many_factors();
    test_all_ones();
    test_random_numbers();
    in_valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/pf_pkg.sv
src/pf_front.sv
src/pf_queue.sv
src/pf_back.sv
src/prime_factorizer_top.sv
verif/tb_top.sv
